[src/wmf_pkg.sv]
// Shared types, constants and register codes of the window median filter.
package wmf_pkg;

  // Default build values.
  localparam int DEF_WIN_W     = 3;
  localparam int DEF_WIN_H     = 3;
  localparam int DEF_MAX_WIDTH = 1024;
  localparam int MAX_HEIGHT    = 4096;

  // Register fields and reset values.
  localparam int WIDTH_BITS  = 11;
  localparam int HEIGHT_BITS = 13;
  localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 13'd480;

  // Depth of the window queue between front and back.
  localparam int QUEUE_DEPTH = 4;

  // Register index codes (byte address bit 2).
  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_t;

  // Frame geometry as programmed.
  typedef struct packed {
    logic [WIDTH_BITS-1:0]  width;
    logic [HEIGHT_BITS-1:0] height;
  } cfg_t;

endpackage

[src/window_median_filter.sv]
// Top level of the streaming window median filter.
// One 8-bit pixel enters per clock in raster order while full is low and,
// once the window is full, one median leaves per clock while pop is high:
// sustained rate one item per cycle when nothing stalls. A result passes the
// front's stage-two registers, the window queue and the sorting pipeline,
// and waits while the result side stalls. A four-entry window queue
// decouples the line-store front from the sorter; full rises when that queue
// and the item in the front could not both be absorbed. The line stores are
// not cleared; only windows of rows written in the same frame are passed on.
module window_median_filter #(
  parameter int WIN_W     = wmf_pkg::DEF_WIN_W,
  parameter int WIN_H     = wmf_pkg::DEF_WIN_H,
  parameter int MAX_WIDTH = wmf_pkg::DEF_MAX_WIDTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_pixel,
  input  logic        in_frame_start,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_median,
  output logic        out_frame_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import wmf_pkg::*;

  localparam int KW = (WIN_W / 2) * 2 + 1;
  localparam int KH = (WIN_H / 2) * 2 + 1;
  localparam int N  = KW * KH;
  localparam int QW = $clog2(QUEUE_DEPTH + 1);

  cfg_t            cfg;
  logic            accept, pending, f_push, f_last;
  logic [N*8-1:0]  f_win;
  logic [N*8:0]    q_data;
  logic            q_ne, take, out_v;
  logic [QW-1:0]   q_cnt;

  assign accept = push && !full;
  assign full   = ({1'b0, q_cnt} + (QW+1)'(pending)) >= (QW+1)'(QUEUE_DEPTH);
  assign empty  = !out_v;

  wmf_cfg u_cfg (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg
  );

  wmf_front #(.KW(KW), .KH(KH), .MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk, .rst_n, .cfg, .accept,
    .pixel(in_pixel), .frame_start(in_frame_start),
    .pending, .push(f_push), .win(f_win), .last(f_last)
  );

  wmf_queue #(.DW(N*8+1), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst_n, .wr(f_push), .wdata({f_last, f_win}),
    .rd(take), .rdata(q_data), .nonempty(q_ne), .count(q_cnt)
  );

  wmf_sort #(.N(N)) u_sort (
    .clk, .rst_n, .in_v(q_ne), .in_win(q_data[N*8-1:0]), .in_last(q_data[N*8]),
    .take, .out_v, .median(out_median), .last(out_frame_last), .pop
  );

endmodule

[src/wmf_cfg.sv]
// Configuration register bank with an APB-style slave port.
module wmf_cfg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready,
  output wmf_pkg::cfg_t  cfg
);
  import wmf_pkg::*;

  logic [WIDTH_BITS-1:0]  width_r;
  logic [HEIGHT_BITS-1:0] height_r;
  logic                   wr_en;
  reg_idx_t               idx;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[2]);
  assign wr_en  = psel && penable && pwrite;

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (wr_en && paddr[1:0] == 2'b00) begin
      case (idx)
        REG_WIDTH:  width_r  <= pwdata[WIDTH_BITS-1:0];
        REG_HEIGHT: height_r <= pwdata[HEIGHT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Read mux.
  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      case (idx)
        REG_WIDTH:  prdata = {{(32-WIDTH_BITS){1'b0}}, width_r};
        REG_HEIGHT: prdata = {{(32-HEIGHT_BITS){1'b0}}, height_r};
        default:    prdata = '0;
      endcase
    end
  end

  assign cfg.width  = width_r;
  assign cfg.height = height_r;

endmodule

[src/wmf_front.sv]
// Front end: raster counters, line stores and the pixel window.
module wmf_front #(
  parameter int KW        = 3,
  parameter int KH        = 3,
  parameter int MAX_WIDTH = wmf_pkg::DEF_MAX_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  wmf_pkg::cfg_t        cfg,
  input  logic                 accept,
  input  logic [7:0]           pixel,
  input  logic                 frame_start,
  output logic                 pending,
  output logic                 push,
  output logic [KW*KH*8-1:0]   win,
  output logic                 last
);
  import wmf_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int LSN = (KH > 1) ? KH - 1 : 1;
  localparam logic [12:0] MAXW13 = 13'(MAX_WIDTH);
  localparam logic [12:0] MAXH13 = 13'(MAX_HEIGHT);

  logic [CW-1:0] col_r;
  logic [RW-1:0] row_r;
  logic [12:0]   w_eff, h_eff, c0, r0, r1, r2, xn, yn;
  logic [CW-1:0] x;
  logic [RW-1:0] y;
  logic          ok, lst;

  logic          s2_v_r, ok2_r, last2_r, fwd_r;
  logic [CW-1:0] x2_r;
  logic [7:0]    pix2_r;
  logic [7:0]    rd_r   [LSN];
  logic [7:0]    fwd_col_r [LSN];
  logic [7:0]    colv   [KH];
  logic [7:0]    win_r  [KH][KW];
  logic [7:0]    win_nxt[KH][KW];

  // Effective geometry with saturation.
  always_comb begin
    w_eff = {2'b00, cfg.width};
    if (w_eff == 13'd0) w_eff = 13'd1;
    if (w_eff > MAXW13) w_eff = MAXW13;
    h_eff = cfg.height;
    if (h_eff == 13'd0) h_eff = 13'd1;
    if (h_eff > MAXH13) h_eff = MAXH13;
  end

  // Position of the incoming pixel.
  always_comb begin
    c0 = frame_start ? 13'd0 : 13'(col_r);
    r0 = frame_start ? 13'd0 : 13'(row_r);
    r1 = r0;
    if (c0 >= w_eff) begin
      c0 = 13'd0;
      r1 = r0 + 13'd1;
    end
    r2 = (r1 >= h_eff) ? 13'd0 : r1;
    x  = c0[CW-1:0];
    y  = r2[RW-1:0];
    ok  = (r2 >= 13'(KH - 1)) && (c0 >= 13'(KW - 1));
    lst = (r2 == h_eff - 13'd1) && (c0 == w_eff - 13'd1);
    xn = c0 + 13'd1;
    yn = r2;
    if (xn >= w_eff) begin
      xn = 13'd0;
      yn = (r2 + 13'd1 >= h_eff) ? 13'd0 : r2 + 13'd1;
    end
  end

  // Counters and stage-two control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      s2_v_r <= 1'b0;
      fwd_r  <= 1'b0;
    end else begin
      s2_v_r <= accept;
      if (accept) begin
        col_r <= xn[CW-1:0];
        row_r <= yn[RW-1:0];
        fwd_r <= s2_v_r && (x2_r == x);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x2_r    <= x;
      pix2_r  <= pixel;
      ok2_r   <= ok;
      last2_r <= lst;
    end
  end

  // Column assembly: line-store data, forwarded when the same column was
  // written in the cycle it was read.
  always_comb begin
    for (int i = 0; i < KH - 1; i++) begin
      colv[i] = fwd_r ? fwd_col_r[i % LSN] : rd_r[i % LSN];
    end
    colv[KH-1] = pix2_r;
  end

  // Line stores, one memory per stored row.
  for (genvar g = 0; g < LSN; g++) begin : g_ls
    if (KH > 1) begin : g_mem
      logic [7:0] mem [MAX_WIDTH];
      always_ff @(posedge clk) begin
        if (accept) rd_r[g] <= mem[x];
        if (s2_v_r) mem[x2_r] <= colv[g+1];
      end
      always_ff @(posedge clk) begin
        if (accept) fwd_col_r[g] <= colv[g+1];
      end
    end else begin : g_none
      always_ff @(posedge clk) begin
        rd_r[g]      <= pix2_r;
        fwd_col_r[g] <= pix2_r;
      end
    end
  end

  // Window shift.
  always_comb begin
    for (int r = 0; r < KH; r++) begin
      for (int c = 0; c < KW - 1; c++) win_nxt[r][c] = win_r[r][c+1];
      win_nxt[r][KW-1] = colv[r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < KH; r++)
        for (int c = 0; c < KW; c++) win_r[r][c] <= '0;
    end else if (s2_v_r) begin
      win_r <= win_nxt;
    end
  end

  // Items with a full window go to the queue.
  always_comb begin
    for (int r = 0; r < KH; r++)
      for (int c = 0; c < KW; c++) win[(r*KW+c)*8 +: 8] = win_nxt[r][c];
  end

  assign push    = s2_v_r && ok2_r;
  assign last    = last2_r;
  assign pending = push;

endmodule

[src/wmf_queue.sv]
// Short FIFO of windows between front and back.
module wmf_queue #(
  parameter int DW    = 73,
  parameter int DEPTH = wmf_pkg::QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       wr,
  input  logic [DW-1:0]              wdata,
  input  logic                       rd,
  output logic [DW-1:0]              rdata,
  output logic                       nonempty,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DW-1:0] mem [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [$clog2(DEPTH+1)-1:0] cnt_r;
  logic          do_rd;

  assign do_rd    = rd && (cnt_r != '0);
  assign nonempty = (cnt_r != '0);
  assign rdata    = mem[rp_r];
  assign count    = cnt_r;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (do_rd) rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (wr ? 1'b1 : 1'b0) - (do_rd ? 1'b1 : 1'b0);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem[wp_r] <= wdata;
  end

endmodule

[src/wmf_sort.sv]
// Back end: odd-even transposition sorting pipeline, median at its end.
module wmf_sort #(
  parameter int N = 9
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_v,
  input  logic [N*8-1:0] in_win,
  input  logic           in_last,
  output logic           take,
  output logic           out_v,
  output logic [7:0]     median,
  output logic           last,
  input  logic           pop
);
  logic       adv;
  logic       v_r    [N];
  logic       lst_r  [N];
  logic [7:0] st_r   [N][N];
  logic [7:0] st_in  [N][N];
  logic [7:0] st_out [N][N];

  // The whole pipeline moves unless a finished item waits at the end.
  assign adv  = !v_r[N-1] || pop;
  assign take = adv && in_v;

  always_comb begin
    for (int e = 0; e < N; e++) st_in[0][e] = in_win[e*8 +: 8];
    for (int k = 1; k < N; k++) st_in[k] = st_r[k-1];
  end

  // One compare-exchange layer per stage, alternating pair offsets.
  always_comb begin
    for (int k = 0; k < N; k++) begin
      st_out[k] = st_in[k];
      for (int e = k % 2; e + 1 < N; e += 2) begin
        if (st_in[k][e] > st_in[k][e+1]) begin
          st_out[k][e]   = st_in[k][e+1];
          st_out[k][e+1] = st_in[k][e];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < N; k++) v_r[k] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= in_v;
      for (int k = 1; k < N; k++) v_r[k] <= v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r     <= st_out;
      lst_r[0] <= in_last;
      for (int k = 1; k < N; k++) lst_r[k] <= lst_r[k-1];
    end
  end

  assign out_v  = v_r[N-1];
  assign median = st_r[N-1][N/2];
  assign last   = lst_r[N-1];

endmodule

[src/wmf_checker.sv]
// Port-level checker for the window median filter, bound to the top level.
module wmf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        push,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [7:0]  out_median,
  input logic        out_frame_last,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata
);

  // Nothing is waiting right after reset.
  a_empty_after_reset: assert property (@(posedge clk)
    (rst_n && $past(!rst_n)) |-> empty) else $error("result waiting after reset");

  // The input side is open right after reset.
  a_open_after_reset: assert property (@(posedge clk)
    (rst_n && $past(!rst_n)) |-> !full) else $error("full after reset");

  // A written width reads back.
  a_width_readback: assert property (@(posedge clk) disable iff (!rst_n)
    (psel && penable && pwrite && paddr == 3'd0) ##1
      (!(psel && penable && pwrite) && paddr == 3'd0)
    |-> prdata[10:0] == $past(pwdata[10:0]))
    else $error("width register readback mismatch");

  // A waiting item holds while not taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_median) && $stable(out_frame_last)))
    else $error("waiting item changed");

endmodule

bind window_median_filter wmf_checker u_wmf_checker (
  .clk, .rst_n, .push, .full, .empty, .pop, .out_median, .out_frame_last,
  .psel, .penable, .pwrite, .paddr, .pwdata, .prdata
);
